FILE: hdl/pixel_color_class_counter_assert.svh
// Assertion macros used by the checker file of the pixel color class counter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PIXEL_COLOR_CLASS_COUNTER_ASSERT_SVH
`define PIXEL_COLOR_CLASS_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PCCC_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error("pccc assertion failed");

// Next-cycle implication, disabled during reset
`define PCCC_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error("pccc assertion failed");

`endif

FILE: hdl/pccc_pkg.sv
// Package for the pixel color class counter: widths, thresholds, caps and helpers.
// No dependencies; used by the interfaces, the top level and the checker.
package pccc_pkg;

    // Field widths
    localparam int CH_W  = 8;
    localparam int BRI_W = 8;
    localparam int CNT_W = 23;
    localparam int SUM_W = 30;

    // Frame size bound and largest per-pixel saturation (max minus mean)
    localparam longint MAX_FRAME_PIXELS = 4194304;
    localparam longint SAT_MAX          = 170;

    // Counter caps: frame bound or the full register range, whichever is smaller
    localparam longint CNT_LIMIT = (longint'(1) << CNT_W) - 1;
    localparam longint SUM_LIMIT = (longint'(1) << SUM_W) - 1;
    localparam longint CNT_CAP_L =
        (MAX_FRAME_PIXELS < CNT_LIMIT) ? MAX_FRAME_PIXELS : CNT_LIMIT;
    localparam longint SUM_CAP_L =
        ((MAX_FRAME_PIXELS * SAT_MAX) < SUM_LIMIT) ? (MAX_FRAME_PIXELS * SAT_MAX) : SUM_LIMIT;
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_L);
    localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(SUM_CAP_L);

    // Mean of three channels: sum * 683 >> 11 equals sum / 3 for sums up to 765
    localparam int RGB_SUM_W = CH_W + 2;
    localparam int AVG_RECIP_W = 10;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'(683);
    localparam int AVG_SHIFT = 11;
    localparam int AVG_PROD_W = RGB_SUM_W + AVG_RECIP_W;

    // Thresholds of the class rules
    localparam logic [CH_W-1:0] RED_MIN      = CH_W'(100);
    localparam logic [CH_W-1:0] PINK_G_MAX   = CH_W'(58);
    localparam logic [CH_W-1:0] SKIN_G_MIN   = CH_W'(78);
    localparam logic [CH_W-1:0] SKIN_B_MIN   = CH_W'(68);
    localparam logic [CH_W-1:0] SKIN_B_MAX   = CH_W'(150);
    localparam logic [CH_W-1:0] SKIN_RB_DIFF = CH_W'(32);
    localparam logic [CH_W-1:0] SKIN_AVG_MIN = CH_W'(109);
    localparam logic [CH_W-1:0] SKIN_RA_DIFF = CH_W'(38);
    localparam logic [CH_W:0]   PAIR_SUM_MAX = (CH_W+1)'(250);
    localparam logic [CH_W-1:0] BLUE_B_MIN   = CH_W'(25);
    localparam logic [CH_W-1:0] BLUE_B_MID   = CH_W'(90);
    localparam logic [CH_W-1:0] BLUE_R_MAX   = CH_W'(38);
    localparam logic [CH_W-1:0] BLUE_BG_DIFF = CH_W'(4);
    localparam logic [CH_W-1:0] GREEN_G_MIN  = CH_W'(40);

    // Brightness branch limits
    localparam logic [BRI_W-1:0] BRI_DARK   = BRI_W'(40);
    localparam logic [BRI_W-1:0] BRI_BRIGHT = BRI_W'(50);

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Saturating count increment
    function automatic logic [CNT_W-1:0] cnt_bump(input logic [CNT_W-1:0] cnt,
                                                  input logic inc);
        logic [CNT_W:0] s;
        s = {1'b0, cnt} + (CNT_W+1)'(inc);
        return (s < {1'b0, CNT_CAP}) ? s[CNT_W-1:0] : CNT_CAP;
    endfunction

    // Saturating sum accumulate
    function automatic logic [SUM_W-1:0] sum_bump(input logic [SUM_W-1:0] acc,
                                                  input logic [CH_W-1:0] add);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W+1)'(add);
        return (s < {1'b0, SUM_CAP}) ? s[SUM_W-1:0] : SUM_CAP;
    endfunction

endpackage

FILE: hdl/pccc_pix_if.sv
// Pixel input channel: valid/ready handshake with one BGR pixel per transaction.
// Depends on pccc_pkg for the channel width.
interface pccc_pix_if
    import pccc_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] red_in;
    logic            last_pixel;

    modport source (output valid, blue_in, green_in, red_in, last_pixel, input ready);
    modport sink   (input valid, blue_in, green_in, red_in, last_pixel, output ready);
endinterface

FILE: hdl/pccc_res_if.sv
// Result channel: valid/ready handshake with class flags and frame totals.
// Depends on pccc_pkg for the total widths.
interface pccc_res_if
    import pccc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             skin_flag;
    logic             pink_flag;
    logic             blue_flag;
    logic             green_flag;
    logic [CNT_W-1:0] skin_total;
    logic [CNT_W-1:0] pink_total;
    logic [CNT_W-1:0] blue_total;
    logic [CNT_W-1:0] green_total;
    logic [SUM_W-1:0] saturation_total;
    logic             frame_done;

    modport source (output valid, skin_flag, pink_flag, blue_flag, green_flag,
                    skin_total, pink_total, blue_total, green_total,
                    saturation_total, frame_done, input ready);
    modport sink   (input valid, skin_flag, pink_flag, blue_flag, green_flag,
                    skin_total, pink_total, blue_total, green_total,
                    saturation_total, frame_done, output ready);
endinterface

FILE: hdl/pixel_color_class_counter.sv
// Pixel color class counter top level.
// Depends on pccc_pkg, pccc_pix_if and pccc_res_if.
//
// Usage:
//   pix  - input channel, one BGR pixel per transaction; last_pixel marks the
//          final pixel of a frame.
//   res  - result channel, one transaction per pixel: skin/pink/blue/green flags,
//          running per-frame totals that include this pixel, and frame_done.
//   cfg_we/cfg_data - brightness level write; selects the skin and blue rule
//          branches. Write it only while no pixel is in flight.
// Timing: a pixel taken on pix goes from the input register to the result register,
//   which drives res (two register stages: input register, result register). One
//   pixel per cycle is sustained while res stays ready; the per-pixel logic (mean by
//   constant multiply, compares, saturating adds) sits between those two registers.
// Reset: clears the brightness level, both valid bits and all accumulators.
// Stall: while res is held, the result register keeps its transaction and one
//   more pixel can wait in the input register; pix.ready then drops.
// After the result with frame_done is produced, all accumulators restart at zero.
module pixel_color_class_counter
    import pccc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    pccc_pix_if.sink         pix,
    pccc_res_if.source       res,
    input  logic             cfg_we,
    input  logic [BRI_W-1:0] cfg_data
);

    logic [BRI_W-1:0] brightness_reg;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [CH_W-1:0]  in_blue_reg;
    logic [CH_W-1:0]  in_green_reg;
    logic [CH_W-1:0]  in_red_reg;
    logic             in_last_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_skin_reg;
    logic             out_pink_reg;
    logic             out_blue_reg;
    logic             out_green_reg;
    logic [CNT_W-1:0] out_skin_total_reg;
    logic [CNT_W-1:0] out_pink_total_reg;
    logic [CNT_W-1:0] out_blue_total_reg;
    logic [CNT_W-1:0] out_green_total_reg;
    logic [SUM_W-1:0] out_sat_total_reg;
    logic             out_done_reg;

    logic [CNT_W-1:0] skin_count_reg;
    logic [CNT_W-1:0] pink_count_reg;
    logic [CNT_W-1:0] blue_count_reg;
    logic [CNT_W-1:0] green_count_reg;
    logic [SUM_W-1:0] sat_sum_reg;
    logic [CNT_W-1:0] skin_count_next;
    logic [CNT_W-1:0] pink_count_next;
    logic [CNT_W-1:0] blue_count_next;
    logic [CNT_W-1:0] green_count_next;
    logic [SUM_W-1:0] sat_sum_next;

    logic             in_take;
    logic             out_load;

    logic [RGB_SUM_W-1:0]  rgb_sum;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [CH_W-1:0]       avg;
    logic [CH_W-1:0]       max_ch;
    logic [CH_W-1:0]       sat_pix;
    logic [CH_W:0]         bg_sum;
    logic [CH_W:0]         br_sum;
    logic                  red_dom;
    logic                  pink;
    logic                  skin_branch;
    logic                  skin;
    logic                  blue;
    logic                  green;

    // Handshake: the input register moves on when the result register is free
    assign out_load      = in_valid_reg && (!out_valid_reg || res.ready);
    assign pix.ready     = !in_valid_reg || out_load;
    assign in_take       = pix.valid && pix.ready;
    assign in_valid_next = in_take || (in_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && !res.ready);

    // Channel mean, max and saturation
    assign rgb_sum  = RGB_SUM_W'(in_red_reg) + RGB_SUM_W'(in_green_reg)
                    + RGB_SUM_W'(in_blue_reg);
    assign avg_prod = AVG_PROD_W'(rgb_sum) * AVG_PROD_W'(AVG_RECIP);
    assign avg      = avg_prod[AVG_SHIFT +: CH_W];

    always_comb
    begin
        max_ch = in_red_reg;
        if (in_green_reg > max_ch)
        begin
            max_ch = in_green_reg;
        end
        if (in_blue_reg > max_ch)
        begin
            max_ch = in_blue_reg;
        end
    end

    assign sat_pix = max_ch - avg;
    assign bg_sum  = (CH_W+1)'(in_blue_reg) + (CH_W+1)'(in_green_reg);
    assign br_sum  = (CH_W+1)'(in_blue_reg) + (CH_W+1)'(in_red_reg);

    // Class rules
    assign red_dom = (in_red_reg > in_blue_reg) && (in_red_reg > in_green_reg)
                   && (in_red_reg > RED_MIN);
    assign pink    = red_dom && (in_green_reg < PINK_G_MAX);

    assign skin_branch = ((brightness_reg < BRI_DARK) && (bg_sum < PAIR_SUM_MAX))
                       || ((brightness_reg >= BRI_DARK) && (brightness_reg < BRI_BRIGHT))
                       || ((brightness_reg >= BRI_BRIGHT)
                           && (abs_diff(in_red_reg, avg) > SKIN_RA_DIFF));

    assign skin = red_dom && (in_green_reg > SKIN_G_MIN) && (in_blue_reg > SKIN_B_MIN)
                && (abs_diff(in_red_reg, in_blue_reg) > SKIN_RB_DIFF)
                && (in_blue_reg < SKIN_B_MAX) && (in_red_reg > avg)
                && (avg > SKIN_AVG_MIN) && !pink && skin_branch;

    // Bright branch needs brightness above 50, dark branch below: 50 flags neither
    assign blue = (in_blue_reg > in_red_reg) && (in_blue_reg > in_green_reg)
                && (((brightness_reg < BRI_BRIGHT) && (in_blue_reg < BLUE_B_MID)
                     && (in_blue_reg > BLUE_B_MIN) && (in_red_reg < BLUE_R_MAX)
                     && (abs_diff(in_blue_reg, in_green_reg) > BLUE_BG_DIFF))
                    || ((in_blue_reg > BLUE_B_MID) && (brightness_reg > BRI_BRIGHT)));

    assign green = (max_ch == in_green_reg) && (in_green_reg > GREEN_G_MIN)
                 && (br_sum < PAIR_SUM_MAX);

    // Saturating accumulators, including the current pixel
    assign skin_count_next  = cnt_bump(skin_count_reg, skin);
    assign pink_count_next  = cnt_bump(pink_count_reg, pink);
    assign blue_count_next  = cnt_bump(blue_count_reg, blue);
    assign green_count_next = cnt_bump(green_count_reg, green);
    assign sat_sum_next     = sum_bump(sat_sum_reg, sat_pix);

    // Control state and brightness register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg  <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            skin_count_reg  <= '0;
            pink_count_reg  <= '0;
            blue_count_reg  <= '0;
            green_count_reg <= '0;
            sat_sum_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                brightness_reg <= cfg_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                if (in_last_reg)
                begin
                    skin_count_reg  <= '0;
                    pink_count_reg  <= '0;
                    blue_count_reg  <= '0;
                    green_count_reg <= '0;
                    sat_sum_reg     <= '0;
                end
                else
                begin
                    skin_count_reg  <= skin_count_next;
                    pink_count_reg  <= pink_count_next;
                    blue_count_reg  <= blue_count_next;
                    green_count_reg <= green_count_next;
                    sat_sum_reg     <= sat_sum_next;
                end
            end
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_blue_reg  <= pix.blue_in;
            in_green_reg <= pix.green_in;
            in_red_reg   <= pix.red_in;
            in_last_reg  <= pix.last_pixel;
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_skin_reg        <= skin;
            out_pink_reg        <= pink;
            out_blue_reg        <= blue;
            out_green_reg       <= green;
            out_skin_total_reg  <= skin_count_next;
            out_pink_total_reg  <= pink_count_next;
            out_blue_total_reg  <= blue_count_next;
            out_green_total_reg <= green_count_next;
            out_sat_total_reg   <= sat_sum_next;
            out_done_reg        <= in_last_reg;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.skin_flag        = out_skin_reg;
    assign res.pink_flag        = out_pink_reg;
    assign res.blue_flag        = out_blue_reg;
    assign res.green_flag       = out_green_reg;
    assign res.skin_total       = out_skin_total_reg;
    assign res.pink_total       = out_pink_total_reg;
    assign res.blue_total       = out_blue_total_reg;
    assign res.green_total      = out_green_total_reg;
    assign res.saturation_total = out_sat_total_reg;
    assign res.frame_done       = out_done_reg;

endmodule

FILE: hdl/pccc_checker.sv
// Port-level checker for the pixel color class counter, bound to the top level.
// Depends on pccc_pkg and pixel_color_class_counter_assert.svh.
`include "pixel_color_class_counter_assert.svh"

module pccc_checker
    import pccc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input logic [CNT_W-1:0] skin_total,
    input logic [SUM_W-1:0] saturation_total,
    input logic             frame_done
);

    // A stalled result transaction stays offered
    `PCCC_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid)

    // Within a frame the totals never go down from one transaction to the next
    `PCCC_ASSERT_NXT(a_skin_mono, res_valid && res_ready && !frame_done,
        !res_valid || (skin_total >= $past(skin_total)))
    `PCCC_ASSERT_NXT(a_sat_mono, res_valid && res_ready && !frame_done,
        !res_valid || (saturation_total >= $past(saturation_total)))

    // The first result after a frame ends starts counting from zero again
    `PCCC_ASSERT_NXT(a_frame_restart, res_valid && res_ready && frame_done,
        !res_valid || (skin_total <= CNT_W'(1)))

endmodule

bind pixel_color_class_counter pccc_checker u_pccc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .skin_total       (res.skin_total),
    .saturation_total (res.saturation_total),
    .frame_done       (res.frame_done)
);

FILE: test/testbench.sv
// Self-checking testbench for pixel_color_class_counter: directed table plus random frames.
// Depends on pccc_pkg, pccc_pix_if, pccc_res_if and the pixel_color_class_counter RTL.
`timescale 1ns / 100ps

module testbench;
    import pccc_pkg::*;

    // One pixel as driven on the input channel
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            last;
    } pixel_t;

    // Flags and running frame totals carried by one result transaction
    typedef struct packed {
        logic             skin;
        logic             pink;
        logic             blue;
        logic             green;
        logic [CNT_W-1:0] skin_total;
        logic [CNT_W-1:0] pink_total;
        logic [CNT_W-1:0] blue_total;
        logic [CNT_W-1:0] green_total;
        logic [SUM_W-1:0] sat_total;
        logic             done;
    } tally_t;

    // Directed stimulus row; flags are skin, pink, blue, green from msb down
    typedef struct packed {
        logic [7:0] bri;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
        logic       typed;
        logic [3:0] flags;
        logic [7:0] sat;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [BRI_W-1:0] cfg_data;

    pccc_pix_if pix ();
    pccc_res_if res ();

    pixel_color_class_counter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix      (pix),
        .res      (res),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // Predictor state: brightness copy and per-frame accumulators
    int unsigned brightness_now;
    int unsigned skin_run;
    int unsigned pink_run;
    int unsigned blue_run;
    int unsigned green_run;
    longint      sat_run;

    tally_t      expected_tallies[$];
    int unsigned mismatch_count;
    int unsigned pixels_sent;
    int unsigned frames_sent;
    int unsigned levels_used;
    int unsigned class_hits[4];
    int unsigned burst_left;

    // Typed rows open a fresh frame, so each total equals its flag
    dir_row_t directed_rows [0:22] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 4'b0000, 8'd0},
        '{8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 4'b0000, 8'd0},
        '{8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 1'b1, 4'b0100, 8'd170},
        '{8'd0,   8'd255, 8'd0,   8'd0,   1'b1, 1'b1, 4'b0000, 8'd170},
        '{8'd0,   8'd0,   8'd255, 8'd0,   1'b1, 1'b1, 4'b0001, 8'd170},
        // dark skin branch, then blocked by B+G, then pink
        '{8'd0,   8'd80,  8'd100, 8'd200, 1'b0, 1'b0, 4'b0000, 8'd0},
        '{8'd0,   8'd110, 8'd150, 8'd220, 1'b0, 1'b0, 4'b0000, 8'd0},
        '{8'd0,   8'd40,  8'd50,  8'd150, 1'b0, 1'b0, 4'b0000, 8'd0},
        // dark blue inside and on the upper edge
        '{8'd0,   8'd60,  8'd30,  8'd20,  1'b0, 1'b0, 4'b0000, 8'd0},
        '{8'd0,   8'd90,  8'd30,  8'd20,  1'b0, 1'b0, 4'b0000, 8'd0},
        '{8'd0,   8'd100, 8'd100, 8'd50,  1'b1, 1'b0, 4'b0000, 8'd0},
        // middle brightness band
        '{8'd45,  8'd110, 8'd150, 8'd220, 1'b0, 1'b0, 4'b0000, 8'd0},
        '{8'd45,  8'd60,  8'd30,  8'd20,  1'b1, 1'b0, 4'b0000, 8'd0},
        // brightness exactly 50: no blue branch applies
        '{8'd50,  8'd200, 8'd50,  8'd20,  1'b0, 1'b0, 4'b0000, 8'd0},
        '{8'd50,  8'd60,  8'd30,  8'd20,  1'b0, 1'b0, 4'b0000, 8'd0},
        '{8'd50,  8'd80,  8'd100, 8'd220, 1'b0, 1'b0, 4'b0000, 8'd0},
        '{8'd50,  8'd140, 8'd150, 8'd180, 1'b1, 1'b0, 4'b0000, 8'd0},
        // bright blue branch
        '{8'd51,  8'd200, 8'd50,  8'd20,  1'b0, 1'b0, 4'b0000, 8'd0},
        '{8'd51,  8'd91,  8'd90,  8'd0,   1'b1, 1'b0, 4'b0000, 8'd0},
        '{8'd255, 8'd255, 8'd254, 8'd254, 1'b0, 1'b0, 4'b0000, 8'd0},
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 4'b0000, 8'd0},
        // both edges of the dark band
        '{8'd39,  8'd80,  8'd100, 8'd200, 1'b1, 1'b0, 4'b0000, 8'd0},
        '{8'd40,  8'd110, 8'd150, 8'd220, 1'b1, 1'b0, 4'b0000, 8'd0}
    };

    // Clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned chan_gap(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int unsigned count_up(input int unsigned cnt, input logic hit);
        int unsigned s;
        s = cnt + (hit ? 1 : 0);
        return (s < CNT_CAP) ? s : CNT_CAP;
    endfunction

    // Classify one pixel, advance the frame accumulators, return the expected transaction
    task automatic classify_pixel(input pixel_t px, output tally_t t);
        int unsigned b, g, r, avg, mx;
        logic        is_pink, is_skin, is_blue, is_green, skin_branch;
        longint      s;
        b = px.blue;
        g = px.green;
        r = px.red;
        avg = (r + g + b) / 3;
        mx = (r > g) ? r : g;
        if (b > mx) mx = b;

        is_pink = r > b && r > g && r > 100 && g < 58;
        skin_branch = (brightness_now < 40 && b + g < 250) ||
                      (brightness_now >= 40 && brightness_now < 50) ||
                      (brightness_now >= 50 && chan_gap(r, avg) > 38);
        is_skin = r > b && r > g && r > 100 && g > 78 && b > 68 &&
                  chan_gap(r, b) > 32 && b < 150 && r > avg && avg > 109 &&
                  !is_pink && skin_branch;
        is_blue = b > r && b > g &&
                  ((brightness_now < 50 && b < 90 && b > 25 && r < 38 &&
                    chan_gap(b, g) > 4) ||
                   (b > 90 && brightness_now > 50));
        is_green = mx == g && g > 40 && b + r < 250;

        skin_run  = count_up(skin_run, is_skin);
        pink_run  = count_up(pink_run, is_pink);
        blue_run  = count_up(blue_run, is_blue);
        green_run = count_up(green_run, is_green);
        s = sat_run + (mx - avg);
        sat_run = (s < SUM_CAP) ? s : SUM_CAP;

        t.skin        = is_skin;
        t.pink        = is_pink;
        t.blue        = is_blue;
        t.green       = is_green;
        t.skin_total  = CNT_W'(skin_run);
        t.pink_total  = CNT_W'(pink_run);
        t.blue_total  = CNT_W'(blue_run);
        t.green_total = CNT_W'(green_run);
        t.sat_total   = SUM_W'(sat_run);
        t.done        = px.last;

        class_hits[0] += is_skin;
        class_hits[1] += is_pink;
        class_hits[2] += is_blue;
        class_hits[3] += is_green;

        // last pixel closes the frame
        if (px.last)
        begin
            skin_run  = 0;
            pink_run  = 0;
            blue_run  = 0;
            green_run = 0;
            sat_run   = 0;
            frames_sent++;
        end
    endtask

    // Drive one pixel and hold it until the transaction completes
    task automatic send_pixel(input pixel_t px, input logic typed, input tally_t typed_want);
        tally_t want;
        pix.valid      <= 1'b1;
        pix.blue_in    <= px.blue;
        pix.green_in   <= px.green;
        pix.red_in     <= px.red;
        pix.last_pixel <= px.last;
        do
            @(posedge clk);
        while (pix.ready !== 1'b1);
        classify_pixel(px, want);
        expected_tallies.insert(expected_tallies.size(), typed ? typed_want : want);
        pixels_sent++;
    endtask

    // Bursts of random length separated by random gaps
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                pix.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Stop sending until every outstanding result has arrived
    task automatic wait_for_tallies();
        pix.valid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_level(input int unsigned lvl);
        cfg_we   <= 1'b1;
        cfg_data <= BRI_W'(lvl);
        @(posedge clk);
        cfg_we <= 1'b0;
        brightness_now = lvl;
        levels_used++;
    endtask

    // Random pixel, biased toward each class region
    function automatic pixel_t random_pixel();
        pixel_t px;
        int unsigned top;
        case ($urandom_range(0, 5))
            0:
            begin
                px.red   = CH_W'($urandom_range(100, 255));
                px.green = CH_W'($urandom_range(70, 200));
                px.blue  = CH_W'($urandom_range(60, 160));
            end
            1:
            begin
                px.red   = CH_W'($urandom_range(90, 255));
                px.green = CH_W'($urandom_range(0, 70));
                px.blue  = CH_W'($urandom_range(0, 120));
            end
            2:
            begin
                px.blue  = CH_W'($urandom_range(20, 100));
                px.green = CH_W'($urandom_range(0, 100));
                px.red   = CH_W'($urandom_range(0, 50));
            end
            3:
            begin
                top      = $urandom_range(80, 255);
                px.blue  = CH_W'(top);
                px.green = CH_W'($urandom_range(0, top));
                px.red   = CH_W'($urandom_range(0, top));
            end
            4:
            begin
                top      = $urandom_range(30, 255);
                px.green = CH_W'(top);
                px.blue  = CH_W'($urandom_range(0, top));
                px.red   = CH_W'($urandom_range(0, top));
            end
            default:
            begin
                px.blue  = CH_W'($urandom_range(0, 255));
                px.green = CH_W'($urandom_range(0, 255));
                px.red   = CH_W'($urandom_range(0, 255));
            end
        endcase
        px.last = ($urandom_range(0, 19) == 0);
        return px;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Receiver stall pattern, reshuffled as stall_step advances; all-ready stretches included
    int unsigned stall_step = 0;
    logic [15:0] stall_pattern;
    always @(posedge clk)
    begin
        if (stall_step % 48 == 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_pattern = '1;
                1:       stall_pattern = 16'($urandom & $urandom) | 16'h0001;
                default: stall_pattern = 16'($urandom) | 16'h0001;
            endcase
        end
        res.ready <= stall_pattern[stall_step % 16];
        stall_step++;
    end

    // Result checker: every result transaction against the oldest expectation
    always @(posedge clk)
    begin
        tally_t want;
        if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
        begin
            if (expected_tallies.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none actual frame_done=%0b",
                         $time, res.frame_done);
            end
            else
            begin
                want = expected_tallies.pop_front();
                check_field("skin_flag", want.skin, res.skin_flag);
                check_field("pink_flag", want.pink, res.pink_flag);
                check_field("blue_flag", want.blue, res.blue_flag);
                check_field("green_flag", want.green, res.green_flag);
                check_field("skin_total", want.skin_total, res.skin_total);
                check_field("pink_total", want.pink_total, res.pink_total);
                check_field("blue_total", want.blue_total, res.blue_total);
                check_field("green_total", want.green_total, res.green_total);
                check_field("saturation_total", want.sat_total, res.saturation_total);
                check_field("frame_done", want.done, res.frame_done);
            end
        end
    end

    // Stimulus
    initial
    begin
        int unsigned phase_levels[7] = '{0, 255, 50, 39, 40, 49, 51};
        dir_row_t    row;
        pixel_t      px;
        tally_t      typed_want;
        tally_t      blank;
        int unsigned lvl;
        blank = '0;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        pix.valid      = 1'b0;
        pix.blue_in    = '0;
        pix.green_in   = '0;
        pix.red_in     = '0;
        pix.last_pixel = 1'b0;
        brightness_now = 0;
        skin_run       = 0;
        pink_run       = 0;
        blue_run       = 0;
        green_run      = 0;
        sat_run        = 0;
        mismatch_count = 0;
        pixels_sent    = 0;
        frames_sent    = 0;
        levels_used    = 0;
        class_hits     = '{0, 0, 0, 0};
        burst_left     = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < $size(directed_rows); i++)
        begin
            row = directed_rows[i];
            if (row.bri != brightness_now)
            begin
                wait_for_tallies();
                write_level(row.bri);
            end
            px = '{row.blue, row.green, row.red, row.last};
            typed_want = '{row.flags[3], row.flags[2], row.flags[1], row.flags[0],
                           CNT_W'(row.flags[3]), CNT_W'(row.flags[2]),
                           CNT_W'(row.flags[1]), CNT_W'(row.flags[0]),
                           SUM_W'(row.sat), row.last};
            send_pixel(px, row.typed, typed_want);
            pace_sender();
        end

        // Random frames over a series of brightness settings
        for (int ph = 0; ph < 9; ph++)
        begin
            lvl = (ph < 7) ? phase_levels[ph] : $urandom_range(0, 255);
            wait_for_tallies();
            write_level(lvl);
            for (int k = 0; k < 115; k++)
            begin
                send_pixel(random_pixel(), 1'b0, blank);
                if ($urandom_range(0, 149) == 0)
                    wait_for_tallies();
                else
                    pace_sender();
            end
        end

        // Drain and let the pipeline settle
        pix.valid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d pixels in %0d closed frames across %0d brightness writes.",
                 pixels_sent, frames_sent, levels_used);
        $display("Class hits: skin %0d, pink %0d, blue %0d, green %0d; mismatches %0d.",
                 class_hits[0], class_hits[1], class_hits[2], class_hits[3],
                 mismatch_count);
        if (mismatch_count == 0)
            $display("pixel_color_class_counter: match");
        else
            $display("pixel_color_class_counter: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("Timeout with %0d results outstanding.", expected_tallies.size());
        $display("pixel_color_class_counter: mismatch");
        $finish;
    end

endmodule
